[hw/rtl/dsew_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Direction score evidence weighting: shared package
// Widths, fixed-point constants, register indexes and the structs that pass
// between the preparation stages, the dividers and the scaling stages.
// ----------------------------------------------------------------------------
package dsew_pkg;

   localparam int MAX_DIRECTIONS = 256;

   localparam int COUNT_W = 9;
   localparam int DIR_W   = 8;
   localparam int SCORE_W = 16;
   localparam int EVID_W  = 16;
   localparam int BIAS_W  = 16;
   localparam int CSR_W   = 16;
   localparam int FRAC_W  = 17;
   localparam int DSQ_W   = 2 * COUNT_W;
   localparam int MSQ_W   = 2 * (COUNT_W - 1);
   localparam int NUM_W   = 40;
   localparam int DEN_W   = 25;
   localparam int QUOT_W  = 17;

   localparam int PREP_STAGES  = 3;
   localparam int SCALE_STAGES = 3;
   localparam int LATENCY      = PREP_STAGES + QUOT_W + SCALE_STAGES;

   localparam logic [FRAC_W-1:0] FRAC_ONE  = FRAC_W'(65536);
   localparam logic [FRAC_W-1:0] PEN_OUTER = FRAC_W'(32768);
   localparam logic [FRAC_W-1:0] PEN_INNER = FRAC_W'(52429);

   localparam logic [COUNT_W-1:0] DIR_COUNT_MIN   = COUNT_W'(3);
   localparam logic [COUNT_W-1:0] DIR_COUNT_MAX   = COUNT_W'(MAX_DIRECTIONS);
   localparam logic [COUNT_W-1:0] DIR_COUNT_RESET = COUNT_W'(19);
   localparam logic [BIAS_W-1:0]  BIAS_RESET      = BIAS_W'(1280);

   typedef enum logic {
      CSR_DIRECTION_COUNT = 1'b0,
      CSR_EVIDENCE_BIAS   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [DIR_W-1:0]   dir;
      logic [SCORE_W-1:0] raw;
      logic [FRAC_W-1:0]  pen;
   } side_type;

   typedef struct packed {
      logic             valid;
      side_type         side;
      logic [NUM_W-1:0] num_e;
      logic [DEN_W-1:0] den_e;
      logic [NUM_W-1:0] num_b;
      logic [DEN_W-1:0] den_b;
   } prep_type;

   typedef struct packed {
      logic [QUOT_W-1:0] quot;
      logic              ovf;
   } div_result_type;

endpackage

[hw/rtl/dsew_prep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Direction score evidence weighting: preparation stages
// Three register stages that form the edge penalty, the distance from the
// fan center and the numerators and denominators of both divisions.
// ----------------------------------------------------------------------------
module dsew_prep (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [dsew_pkg::DIR_W-1:0]    in_dir,
   input  logic [dsew_pkg::SCORE_W-1:0]  in_raw,
   input  logic [dsew_pkg::EVID_W-1:0]   in_count,
   input  logic [dsew_pkg::COUNT_W-1:0]  dir_count,
   input  logic [dsew_pkg::BIAS_W-1:0]   evidence_bias,
   output dsew_pkg::prep_type            prep
);

   logic [dsew_pkg::COUNT_W-1:0] n_eff;
   logic [dsew_pkg::COUNT_W-1:0] last_idx;
   logic [dsew_pkg::COUNT_W-1:0] idx;
   logic [dsew_pkg::COUNT_W-1:0] twice;
   logic [dsew_pkg::COUNT_W-1:0] m_ext;

   logic                          s1_valid_ff, s2_valid_ff, s3_valid_ff;
   dsew_pkg::side_type            s1_side_in, s1_side_ff, s2_side_ff, s3_side_ff;
   logic [dsew_pkg::EVID_W-1:0]   s1_count_ff, s2_count_ff;
   logic [dsew_pkg::DEN_W-1:0]    s1_den_e_in, s1_den_e_ff, s2_den_e_ff, s3_den_e_ff;
   logic [dsew_pkg::COUNT_W-1:0]  s1_d_in, s1_d_ff;
   logic [dsew_pkg::COUNT_W-2:0]  s1_m_in, s1_m_ff;
   logic [dsew_pkg::DSQ_W-1:0]    s2_dsq_in, s2_dsq_ff;
   logic [dsew_pkg::MSQ_W-1:0]    s2_msq_in, s2_msq_ff;
   logic [dsew_pkg::NUM_W-1:0]    s3_num_e_in, s3_num_e_ff;
   logic [dsew_pkg::NUM_W-1:0]    s3_num_b_in, s3_num_b_ff;
   logic [dsew_pkg::DEN_W-1:0]    s3_den_b_in, s3_den_b_ff;

   always_comb begin
      if (dir_count < dsew_pkg::DIR_COUNT_MIN) begin
         n_eff = dsew_pkg::DIR_COUNT_MIN;
      end else if (dir_count > dsew_pkg::DIR_COUNT_MAX) begin
         n_eff = dsew_pkg::DIR_COUNT_MAX;
      end else begin
         n_eff = dir_count;
      end
      last_idx = n_eff - dsew_pkg::COUNT_W'(1);
      s1_m_in  = last_idx[dsew_pkg::COUNT_W-2:0];
      m_ext    = {1'b0, s1_m_in};
      idx      = {1'b0, in_dir};
      twice    = {in_dir, 1'b0};
      if (twice >= m_ext) begin
         s1_d_in = twice - m_ext;
      end else begin
         s1_d_in = m_ext - twice;
      end

      s1_side_in.dir = in_dir;
      s1_side_in.raw = in_raw;
      if (idx == '0 || idx == last_idx) begin
         s1_side_in.pen = dsew_pkg::PEN_OUTER;
      end else if (idx == dsew_pkg::COUNT_W'(1) || idx == last_idx - dsew_pkg::COUNT_W'(1)) begin
         s1_side_in.pen = dsew_pkg::PEN_INNER;
      end else begin
         s1_side_in.pen = dsew_pkg::FRAC_ONE;
      end

      s1_den_e_in = (dsew_pkg::DEN_W'(in_count) << 8) + dsew_pkg::DEN_W'(evidence_bias);
   end

   always_comb begin
      s2_dsq_in = dsew_pkg::DSQ_W'(s1_d_ff) * dsew_pkg::DSQ_W'(s1_d_ff);
      s2_msq_in = dsew_pkg::MSQ_W'(s1_m_ff) * dsew_pkg::MSQ_W'(s1_m_ff);
   end

   always_comb begin
      s3_num_e_in = dsew_pkg::NUM_W'(s2_count_ff) << 24;
      s3_num_b_in = (dsew_pkg::NUM_W'(s2_dsq_ff) << 17) + (dsew_pkg::NUM_W'(s2_dsq_ff) << 16);
      s3_den_b_in = (dsew_pkg::DEN_W'(s2_msq_ff) << 4) + (dsew_pkg::DEN_W'(s2_msq_ff) << 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_side_ff  <= s1_side_in;
      s1_count_ff <= in_count;
      s1_den_e_ff <= s1_den_e_in;
      s1_d_ff     <= s1_d_in;
      s1_m_ff     <= s1_m_in;

      s2_side_ff  <= s1_side_ff;
      s2_count_ff <= s1_count_ff;
      s2_den_e_ff <= s1_den_e_ff;
      s2_dsq_ff   <= s2_dsq_in;
      s2_msq_ff   <= s2_msq_in;

      s3_side_ff  <= s2_side_ff;
      s3_den_e_ff <= s2_den_e_ff;
      s3_num_e_ff <= s3_num_e_in;
      s3_num_b_ff <= s3_num_b_in;
      s3_den_b_ff <= s3_den_b_in;
   end

   assign prep.valid = s3_valid_ff;
   assign prep.side  = s3_side_ff;
   assign prep.num_e = s3_num_e_ff;
   assign prep.den_e = s3_den_e_ff;
   assign prep.num_b = s3_num_b_ff;
   assign prep.den_b = s3_den_b_ff;

endmodule

[hw/rtl/dsew_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Direction score evidence weighting: pipelined divider
// Restoring division with one quotient bit per register stage. A quotient
// that would not fit in the quotient width is flagged as an overflow.
// ----------------------------------------------------------------------------
module dsew_divider (
   input  logic                        clock,
   input  logic [dsew_pkg::NUM_W-1:0]  num,
   input  logic [dsew_pkg::DEN_W-1:0]  den,
   output dsew_pkg::div_result_type    result
);

   logic [dsew_pkg::DEN_W-1:0]  rem_in  [dsew_pkg::QUOT_W];
   logic [dsew_pkg::DEN_W-1:0]  rem_ff  [dsew_pkg::QUOT_W];
   logic [dsew_pkg::DEN_W-1:0]  den_in  [dsew_pkg::QUOT_W];
   logic [dsew_pkg::DEN_W-1:0]  den_ff  [dsew_pkg::QUOT_W];
   logic [dsew_pkg::QUOT_W-1:0] low_in  [dsew_pkg::QUOT_W];
   logic [dsew_pkg::QUOT_W-1:0] low_ff  [dsew_pkg::QUOT_W];
   logic [dsew_pkg::QUOT_W-1:0] quot_in [dsew_pkg::QUOT_W];
   logic [dsew_pkg::QUOT_W-1:0] quot_ff [dsew_pkg::QUOT_W];
   logic                        ovf_in  [dsew_pkg::QUOT_W];
   logic                        ovf_ff  [dsew_pkg::QUOT_W];

   always_comb begin
      logic [dsew_pkg::DEN_W-1:0]  r_src;
      logic [dsew_pkg::DEN_W-1:0]  d_src;
      logic [dsew_pkg::QUOT_W-1:0] l_src;
      logic [dsew_pkg::QUOT_W-1:0] q_src;
      logic                        o_src;
      logic [dsew_pkg::DEN_W:0]    trial;
      logic                        qbit;
      for (int j = 0; j < dsew_pkg::QUOT_W; j++) begin
         if (j == 0) begin
            o_src = dsew_pkg::DEN_W'(num[dsew_pkg::NUM_W-1:dsew_pkg::QUOT_W]) >= den;
            r_src = o_src ? '0 : dsew_pkg::DEN_W'(num[dsew_pkg::NUM_W-1:dsew_pkg::QUOT_W]);
            d_src = den;
            l_src = num[dsew_pkg::QUOT_W-1:0];
            q_src = '0;
         end else begin
            o_src = ovf_ff[j-1];
            r_src = rem_ff[j-1];
            d_src = den_ff[j-1];
            l_src = low_ff[j-1];
            q_src = quot_ff[j-1];
         end
         trial = {r_src, l_src[dsew_pkg::QUOT_W-1]};
         qbit  = trial >= {1'b0, d_src};
         if (qbit) begin
            rem_in[j] = dsew_pkg::DEN_W'(trial - {1'b0, d_src});
         end else begin
            rem_in[j] = trial[dsew_pkg::DEN_W-1:0];
         end
         den_in[j]  = d_src;
         low_in[j]  = {l_src[dsew_pkg::QUOT_W-2:0], 1'b0};
         quot_in[j] = {q_src[dsew_pkg::QUOT_W-2:0], qbit};
         ovf_in[j]  = o_src;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < dsew_pkg::QUOT_W; j++) begin
         rem_ff[j]  <= rem_in[j];
         den_ff[j]  <= den_in[j];
         low_ff[j]  <= low_in[j];
         quot_ff[j] <= quot_in[j];
         ovf_ff[j]  <= ovf_in[j];
      end
   end

   assign result.quot = quot_ff[dsew_pkg::QUOT_W-1];
   assign result.ovf  = ovf_ff[dsew_pkg::QUOT_W-1];

endmodule

[hw/rtl/dsew_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Direction score evidence weighting: scaling stages
// Three multiply stages that apply the evidence factor, the edge penalty and
// the central bias, then saturate the score.
// ----------------------------------------------------------------------------
module dsew_scale (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  dsew_pkg::side_type            in_side,
   input  dsew_pkg::div_result_type      evid,
   input  dsew_pkg::div_result_type      drop,
   output logic                          out_valid,
   output logic [dsew_pkg::SCORE_W-1:0]  out_score,
   output logic [dsew_pkg::DIR_W-1:0]    out_dir
);

   localparam int P1_W = dsew_pkg::SCORE_W + dsew_pkg::FRAC_W;
   localparam int S1_W = P1_W - 16;
   localparam int P2_W = S1_W + dsew_pkg::FRAC_W;
   localparam int S2_W = P2_W - 16;
   localparam int P3_W = S2_W + dsew_pkg::FRAC_W;
   localparam int S3_W = P3_W - 16;

   logic [dsew_pkg::FRAC_W-1:0]  factor_e;
   logic [P1_W-1:0]              prod1;
   logic [P2_W-1:0]              prod2;
   logic [P3_W-1:0]              prod3;

   logic                         t1_valid_ff, t2_valid_ff, out_valid_ff;
   logic [S1_W-1:0]              t1_s_in, t1_s_ff;
   logic [dsew_pkg::FRAC_W-1:0]  t1_b_in, t1_b_ff, t2_b_ff;
   logic [dsew_pkg::FRAC_W-1:0]  t1_pen_ff;
   logic [dsew_pkg::DIR_W-1:0]   t1_dir_ff, t2_dir_ff, out_dir_ff;
   logic [S2_W-1:0]              t2_s_in, t2_s_ff;
   logic [S3_W-1:0]              t3_s;
   logic [dsew_pkg::SCORE_W-1:0] out_score_in, out_score_ff;

   always_comb begin
      factor_e = evid.ovf ? '0 : evid.quot;
      if (drop.ovf || drop.quot[dsew_pkg::QUOT_W-1]) begin
         t1_b_in = '0;
      end else begin
         t1_b_in = dsew_pkg::FRAC_ONE - drop.quot;
      end
      prod1   = P1_W'(in_side.raw) * P1_W'(factor_e);
      t1_s_in = prod1[P1_W-1:16];
   end

   always_comb begin
      prod2   = P2_W'(t1_s_ff) * P2_W'(t1_pen_ff);
      t2_s_in = prod2[P2_W-1:16];
   end

   always_comb begin
      prod3 = P3_W'(t2_s_ff) * P3_W'(t2_b_ff);
      t3_s  = prod3[P3_W-1:16];
      if (t3_s[S3_W-1:dsew_pkg::SCORE_W] != '0) begin
         out_score_in = '1;
      end else begin
         out_score_in = t3_s[dsew_pkg::SCORE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff  <= 1'b0;
         t2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         t1_valid_ff  <= in_valid;
         t2_valid_ff  <= t1_valid_ff;
         out_valid_ff <= t2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      t1_s_ff      <= t1_s_in;
      t1_b_ff      <= t1_b_in;
      t1_pen_ff    <= in_side.pen;
      t1_dir_ff    <= in_side.dir;
      t2_s_ff      <= t2_s_in;
      t2_b_ff      <= t1_b_ff;
      t2_dir_ff    <= t1_dir_ff;
      out_score_ff <= out_score_in;
      out_dir_ff   <= t2_dir_ff;
   end

   assign out_valid = out_valid_ff;
   assign out_score = out_score_ff;
   assign out_dir   = out_dir_ff;

endmodule

[hw/rtl/direction_score_evidence_weighting_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Direction score evidence weighting: top level
// Scales each direction's raw score by its evidence factor, an edge penalty
// and a central bias, with saturation.
//
//   Channel   Handshake               Payload
//   request   start / busy            req_direction_index, req_raw_score,
//                                     req_evidence_count
//   response  rsp_strobe (one cycle)  rsp_final_score, rsp_direction_out
//   csr       csr_we                  csr_index, csr_wdata
//
// A beat is accepted on every cycle with start high; busy stays low.
// A response passes three preparation stages, seventeen divider stages at one
// quotient bit each, three multiply stages. One beat per cycle is sustained.
// Reset clears the pipeline valid bits and loads the register defaults.
// The receiver cannot stall, so nothing in the pipeline ever holds.
// ----------------------------------------------------------------------------
module direction_score_evidence_weighting_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [dsew_pkg::DIR_W-1:0]    req_direction_index,
   input  logic [dsew_pkg::SCORE_W-1:0]  req_raw_score,
   input  logic [dsew_pkg::EVID_W-1:0]   req_evidence_count,
   output logic                          rsp_strobe,
   output logic [dsew_pkg::SCORE_W-1:0]  rsp_final_score,
   output logic [dsew_pkg::DIR_W-1:0]    rsp_direction_out,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [dsew_pkg::CSR_W-1:0]    csr_wdata
);

   logic                          accept;
   logic [dsew_pkg::COUNT_W-1:0]  dir_count_ff;
   logic [dsew_pkg::BIAS_W-1:0]   bias_ff;
   dsew_pkg::prep_type            prep;
   dsew_pkg::div_result_type      evid;
   dsew_pkg::div_result_type      drop;
   logic                          valid_dly_ff [dsew_pkg::QUOT_W];
   dsew_pkg::side_type            side_dly_ff  [dsew_pkg::QUOT_W];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_count_ff <= dsew_pkg::DIR_COUNT_RESET;
         bias_ff      <= dsew_pkg::BIAS_RESET;
      end else if (csr_we) begin
         if (csr_index == dsew_pkg::CSR_DIRECTION_COUNT) begin
            dir_count_ff <= csr_wdata[dsew_pkg::COUNT_W-1:0];
         end else begin
            bias_ff <= csr_wdata[dsew_pkg::BIAS_W-1:0];
         end
      end
   end

   dsew_prep u_prep (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept),
      .in_dir        (req_direction_index),
      .in_raw        (req_raw_score),
      .in_count      (req_evidence_count),
      .dir_count     (dir_count_ff),
      .evidence_bias (bias_ff),
      .prep          (prep)
   );

   dsew_divider u_div_evid (
      .clock  (clock),
      .num    (prep.num_e),
      .den    (prep.den_e),
      .result (evid)
   );

   dsew_divider u_div_bias (
      .clock  (clock),
      .num    (prep.num_b),
      .den    (prep.den_b),
      .result (drop)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < dsew_pkg::QUOT_W; j++) begin
            valid_dly_ff[j] <= 1'b0;
         end
      end else begin
         valid_dly_ff[0] <= prep.valid;
         for (int j = 1; j < dsew_pkg::QUOT_W; j++) begin
            valid_dly_ff[j] <= valid_dly_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      side_dly_ff[0] <= prep.side;
      for (int j = 1; j < dsew_pkg::QUOT_W; j++) begin
         side_dly_ff[j] <= side_dly_ff[j-1];
      end
   end

   dsew_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_dly_ff[dsew_pkg::QUOT_W-1]),
      .in_side   (side_dly_ff[dsew_pkg::QUOT_W-1]),
      .evid      (evid),
      .drop      (drop),
      .out_valid (rsp_strobe),
      .out_score (rsp_final_score),
      .out_dir   (rsp_direction_out)
   );

`ifndef ASSERT_OFF
   a_beat_returns: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(dsew_pkg::LATENCY) rsp_strobe)
      else $error("accepted beat did not produce a response on time");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, dsew_pkg::LATENCY))
      else $error("response without a matching request beat");

   a_bias_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      prep.valid |-> prep.den_b != '0)
      else $error("central bias divider received a zero denominator");
`endif

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the direction score evidence weighting block
// A table of directed beats and register writes covers the field extremes,
// tiny and oversized fans, zero bias and indexes outside the fan. Random
// phases follow under several register settings. Each result is checked field
// by field, oldest first, against an in-bench predictor or a typed row score.
// ----------------------------------------------------------------------------
module tb_top;
   import dsew_pkg::*;

   localparam int PHASES       = 9;
   localparam int PHASE_BEATS  = 150;
   localparam int IDLE_LIMIT   = 2000;
   localparam int PLAN_ROWS    = 28;

   typedef struct {
      logic [SCORE_W-1:0] score;
      logic [DIR_W-1:0]   dir;
   } scored_direction_type;

   typedef enum logic [1:0] {
      STEP_BEAT,
      STEP_FAN,
      STEP_BIAS
   } step_kind_type;

   // Register rows carry their write data in the raw field.
   typedef struct packed {
      step_kind_type      kind;
      logic [DIR_W-1:0]   dir;
      logic [SCORE_W-1:0] raw;
      logic [EVID_W-1:0]  count;
      logic               typed;
      logic [SCORE_W-1:0] score;
   } plan_row_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [DIR_W-1:0]     req_direction_index;
   logic [SCORE_W-1:0]   req_raw_score;
   logic [EVID_W-1:0]    req_evidence_count;
   logic                 rsp_strobe;
   logic [SCORE_W-1:0]   rsp_final_score;
   logic [DIR_W-1:0]     rsp_direction_out;
   logic                 csr_we;
   csr_index_type        csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   logic [COUNT_W-1:0]   cfg_fan_size;
   logic [BIAS_W-1:0]    cfg_evidence_bias;
   scored_direction_type pending_scores[$];
   int                   error_count;
   int                   idle_cycles;

   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{STEP_BEAT, 8'd9,   16'hFFFF, 16'h0000, 1'b1, 16'h0000},
      '{STEP_BEAT, 8'd9,   16'h0000, 16'hFFFF, 1'b1, 16'h0000},
      '{STEP_BEAT, 8'd0,   16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
      '{STEP_BEAT, 8'd1,   16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
      '{STEP_BEAT, 8'd17,  16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
      '{STEP_BEAT, 8'd18,  16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
      '{STEP_BEAT, 8'd19,  16'h8000, 16'h0100, 1'b0, 16'h0000},
      '{STEP_BEAT, 8'd255, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000},
      '{STEP_BEAT, 8'd9,   16'h1234, 16'h0001, 1'b0, 16'h0000},
      '{STEP_BIAS, 8'd0,   16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{STEP_BEAT, 8'd9,   16'hFFFF, 16'h0001, 1'b1, 16'hFFFF},
      '{STEP_BEAT, 8'd9,   16'hABCD, 16'h0000, 1'b1, 16'h0000},
      '{STEP_BEAT, 8'd9,   16'h5555, 16'hFFFF, 1'b1, 16'h5555},
      '{STEP_FAN,  8'd0,   16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{STEP_BEAT, 8'd0,   16'hFFFF, 16'h0005, 1'b0, 16'h0000},
      '{STEP_BEAT, 8'd1,   16'hFFFF, 16'h0005, 1'b0, 16'h0000},
      '{STEP_BEAT, 8'd2,   16'hFFFF, 16'h0005, 1'b0, 16'h0000},
      '{STEP_BEAT, 8'd3,   16'hFFFF, 16'h0005, 1'b0, 16'h0000},
      '{STEP_FAN,  8'd0,   16'h01FF, 16'h0000, 1'b0, 16'h0000},
      '{STEP_BIAS, 8'd0,   16'hFFFF, 16'h0000, 1'b0, 16'h0000},
      '{STEP_BEAT, 8'd0,   16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
      '{STEP_BEAT, 8'd127, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
      '{STEP_BEAT, 8'd128, 16'hC3A5, 16'h7FFF, 1'b0, 16'h0000},
      '{STEP_BEAT, 8'd255, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
      '{STEP_FAN,  8'd0,   16'h0100, 16'h0000, 1'b0, 16'h0000},
      '{STEP_BIAS, 8'd0,   16'h0001, 16'h0000, 1'b0, 16'h0000},
      '{STEP_BEAT, 8'd254, 16'hAAAA, 16'h0001, 1'b0, 16'h0000},
      '{STEP_BEAT, 8'd128, 16'h5555, 16'h8000, 1'b0, 16'h0000}
   };

   direction_score_evidence_weighting_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_direction_index (req_direction_index),
      .req_raw_score       (req_raw_score),
      .req_evidence_count  (req_evidence_count),
      .rsp_strobe          (rsp_strobe),
      .rsp_final_score     (rsp_final_score),
      .rsp_direction_out   (rsp_direction_out),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int effective_fan();
      int fan;
      fan = int'(cfg_fan_size);
      if (fan < 3) fan = 3;
      if (fan > MAX_DIRECTIONS) fan = MAX_DIRECTIONS;
      return fan;
   endfunction

   function automatic logic [SCORE_W-1:0] weigh_direction(input logic [DIR_W-1:0] dir,
                                                          input logic [SCORE_W-1:0] raw,
                                                          input logic [EVID_W-1:0] count);
      bit [63:0] fan, span, twice, spread, denom, evidence, penalty, bias, drop, score;
      fan   = 64'(effective_fan());
      denom = (64'(count) << 8) + 64'(cfg_evidence_bias);
      evidence = (denom == 0) ? 64'd0 : (64'(count) << 24) / denom;
      if (dir == 0 || 64'(dir) == fan - 1) penalty = 64'(PEN_OUTER);
      else if (dir == 1 || 64'(dir) == fan - 2) penalty = 64'(PEN_INNER);
      else penalty = 64'(FRAC_ONE);
      span   = fan - 1;
      twice  = 2 * 64'(dir);
      spread = (twice >= span) ? twice - span : span - twice;
      drop   = (3 * 64'(FRAC_ONE) * spread * spread) / (20 * span * span);
      bias   = (drop >= 64'(FRAC_ONE)) ? 64'd0 : 64'(FRAC_ONE) - drop;
      score = (64'(raw) * evidence) >> 16;
      score = (score * penalty) >> 16;
      score = (score * bias) >> 16;
      if (score > 64'hFFFF) score = 64'hFFFF;
      return score[SCORE_W-1:0];
   endfunction

   task automatic wait_for_drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_W-1:0] value);
      wait_for_drain();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_DIRECTION_COUNT) cfg_fan_size = value[COUNT_W-1:0];
      else cfg_evidence_bias = value[BIAS_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_beat(input logic [DIR_W-1:0] dir, input logic [SCORE_W-1:0] raw,
                            input logic [EVID_W-1:0] count, input int gap,
                            input logic typed, input logic [SCORE_W-1:0] typed_score);
      scored_direction_type expected;
      @(negedge clock);
      start               <= 1'b1;
      req_direction_index <= dir;
      req_raw_score       <= raw;
      req_evidence_count  <= count;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected.dir   = dir;
      expected.score = typed ? typed_score : weigh_direction(dir, raw, count);
      pending_scores = {pending_scores, expected};
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      scored_direction_type expected;
      if (!reset && rsp_strobe) begin
         if (pending_scores.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual score %h dir %0d",
                     $time, rsp_final_score, rsp_direction_out);
         end else begin
            expected = pending_scores.pop_front();
            if (rsp_final_score !== expected.score) begin
               error_count++;
               $display("%0t: final_score mismatch, expected %h actual %h (dir %0d)",
                        $time, expected.score, rsp_final_score, expected.dir);
            end
            if (rsp_direction_out !== expected.dir) begin
               error_count++;
               $display("%0t: direction_out mismatch, expected %0d actual %0d",
                        $time, expected.dir, rsp_direction_out);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_we) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   initial begin
      int                 fan_size;
      int                 pick;
      int                 gap;
      bit                 burst;
      logic [CSR_W-1:0]   fan_value;
      logic [CSR_W-1:0]   bias_value;
      logic [DIR_W-1:0]   dir;
      logic [SCORE_W-1:0] raw;
      logic [EVID_W-1:0]  count;

      reset               = 1'b1;
      start               = 1'b0;
      req_direction_index = '0;
      req_raw_score       = '0;
      req_evidence_count  = '0;
      csr_we              = 1'b0;
      csr_index           = CSR_DIRECTION_COUNT;
      csr_wdata           = '0;
      cfg_fan_size        = DIR_COUNT_RESET;
      cfg_evidence_bias   = BIAS_RESET;
      error_count         = 0;
      idle_cycles         = 0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[row]) begin
         case (directed_plan[row].kind)
            STEP_FAN: begin
               write_register(CSR_DIRECTION_COUNT, directed_plan[row].raw);
            end
            STEP_BIAS: begin
               write_register(CSR_EVIDENCE_BIAS, directed_plan[row].raw);
            end
            default: begin
               send_beat(directed_plan[row].dir, directed_plan[row].raw,
                         directed_plan[row].count, $urandom_range(0, 7),
                         directed_plan[row].typed, directed_plan[row].score);
            end
         endcase
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               fan_value  = 16'd3;
               bias_value = 16'd0;
            end
            1: begin
               fan_value  = 16'd256;
               bias_value = 16'hFFFF;
            end
            2: begin
               fan_value  = 16'hFE13;
               bias_value = BIAS_RESET;
            end
            3: begin
               fan_value  = 16'd511;
               bias_value = 16'd1;
            end
            4: begin
               fan_value  = 16'd1;
               bias_value = 16'd256;
            end
            default: begin
               fan_value = 16'($urandom_range(3, 256));
               case ($urandom_range(0, 3))
                  0: bias_value = 16'd0;
                  1: bias_value = 16'hFFFF;
                  2: bias_value = 16'($urandom_range(0, 4096));
                  default: bias_value = 16'($urandom);
               endcase
            end
         endcase
         write_register(CSR_DIRECTION_COUNT, fan_value);
         write_register(CSR_EVIDENCE_BIAS, bias_value);
         fan_size = effective_fan();
         burst = (phase % 3 == 1);

         for (int beat = 0; beat < PHASE_BEATS; beat++) begin
            if (beat == PHASE_BEATS / 2) wait_for_drain();
            pick = $urandom_range(0, 15);
            case (pick)
               0: dir = '0;
               1: dir = 8'd1;
               2: dir = DIR_W'(fan_size - 2);
               3: dir = DIR_W'(fan_size - 1);
               4: dir = DIR_W'($urandom_range(0, 255));
               default: dir = DIR_W'($urandom_range(0, fan_size - 1));
            endcase
            case ($urandom_range(0, 9))
               0: raw = '0;
               1: raw = 16'hFFFF;
               default: raw = 16'($urandom);
            endcase
            case ($urandom_range(0, 9))
               0: count = '0;
               1: count = 16'hFFFF;
               2, 3: count = 16'($urandom_range(0, 16));
               default: count = 16'($urandom);
            endcase
            gap = burst ? 0 : $urandom_range(0, 7);
            send_beat(dir, raw, count, gap, 1'b0, '0);
         end
      end

      wait_for_drain();
      repeat (LATENCY + 8) @(posedge clock);
      if (error_count == 0 && pending_scores.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/dsew_pkg.sv
hw/rtl/dsew_prep.sv
hw/rtl/dsew_divider.sv
hw/rtl/dsew_scale.sv
hw/rtl/direction_score_evidence_weighting_top.sv
verif/tb_top.sv
